// ===== rtl/jbt_pkg.sv =====
// ----------------------------------------------------------------------------
// jbt_pkg
// shared types and codes for the journal block tracker
// ----------------------------------------------------------------------------
package jbt_pkg;

    localparam int unsigned DEF_TABLE_DEPTH = 32;
    localparam int unsigned DEF_BLOCK_BITS  = 32;

    localparam int unsigned ACTIVE_W   = 6;
    localparam int unsigned LOG_AREA_W = 11;
    localparam int unsigned MAX_OP_W   = 6;
    localparam int unsigned SLOT_W     = 5;
    localparam int unsigned BLKOUT_W   = 32;

    localparam logic [ACTIVE_W-1:0]   ACTIVE_MAX       = '1;
    localparam logic [LOG_AREA_W-1:0] LOG_AREA_RESET   = 11'd33;
    localparam logic [MAX_OP_W-1:0]   MAX_OP_RESET     = 6'd10;

    // register index, taken from paddr[2]
    localparam logic REG_LOG_AREA = 1'b0;
    localparam logic REG_MAX_OP   = 1'b1;

    typedef enum logic [1:0] {
        OP_BEGIN = 2'd0,
        OP_END   = 2'd1,
        OP_LOG   = 2'd2
    } op_t;

    typedef enum logic [3:0] {
        ST_GRANTED  = 4'd0,
        ST_WAIT     = 4'd1,
        ST_RELEASED = 4'd2,
        ST_COMMIT   = 4'd3,
        ST_EMPTY    = 4'd4,
        ST_APPENDED = 4'd5,
        ST_ABSORBED = 4'd6,
        ST_FULL     = 4'd7,
        ST_NO_OP    = 4'd8,
        ST_END_ERR  = 4'd9
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SEARCH,
        S_COMMIT_PRIME,
        S_COMMIT,
        S_EMIT
    } state_t;

endpackage

// ===== rtl/journal_block_tracker.sv =====
// ----------------------------------------------------------------------------
// journal_block_tracker
// tracks the block numbers logged by one journal transaction: admission,
// absorption of repeated writes and the commit run
// ----------------------------------------------------------------------------
//  channel   dir  handshake                    content
//  s_axis    in   s_axis_tvalid/tready          opcode, block_number
//  m_axis    out  m_axis_tvalid/tready          status, block_out, slot, tlast=last
//  apb       in   psel/penable/pwrite/pready    log_area_size (0x0), max_op_blocks (0x4)
//
//  begin, end and error cases: decoded straight into the result register
//  log write: the logged entries are scanned from entry 0 until a match or
//  their end, one table read per cycle, and a miss appends the block
//  commit: the logged entries are read in table order, one ahead of each result
//  the input holds off while an item is in work; a held result stalls the
//  sequencer only where it has a new result to place
//  reset clears counts and control; the table is not cleared, data from
//  unused entries is never used
// ----------------------------------------------------------------------------
module journal_block_tracker
#(
    parameter int unsigned TABLE_DEPTH = jbt_pkg::DEF_TABLE_DEPTH,
    parameter int unsigned BLOCK_BITS  = jbt_pkg::DEF_BLOCK_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // opcode[1:0], block_number[33:2], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // status[3:0], block_out[35:4], slot[40:36], pad
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import jbt_pkg::*;

    localparam int unsigned SB     = (BLOCK_BITS < 32) ? BLOCK_BITS : 32;
    localparam int unsigned IW     = $clog2(TABLE_DEPTH);
    localparam int unsigned CW     = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned PROD_W = ACTIVE_W + 1 + MAX_OP_W;
    localparam int unsigned NEED_W = ((CW > PROD_W) ? CW : PROD_W) + 1;
    localparam int unsigned CMP_W  = ((CW > LOG_AREA_W) ? CW : LOG_AREA_W) + 1;

    state_t                state_reg, state_next;
    logic [1:0]            op_reg;
    logic [SB-1:0]         blk_reg;
    logic [CW-1:0]         idx_reg, idx_next, idx_inc;
    logic                  cmp_vld_reg, cmp_vld_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [ACTIVE_W-1:0]   active_reg, active_next;
    logic [LOG_AREA_W-1:0] log_area_reg;
    logic [MAX_OP_W-1:0]   max_op_reg;

    status_t               res_status_reg, res_status_next;
    logic [SB-1:0]         res_block_reg, res_block_next;
    logic [SLOT_W-1:0]     res_slot_reg, res_slot_next;

    logic                  out_vld_reg, out_vld_next;
    logic [3:0]            out_status_reg, out_status_next;
    logic [BLKOUT_W-1:0]   out_block_reg, out_block_next;
    logic [SLOT_W-1:0]     out_slot_reg, out_slot_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_free;

    logic [SB-1:0]         table_mem [TABLE_DEPTH];
    logic [SB-1:0]         rd_data_reg;
    logic [IW-1:0]         rd_addr;
    logic                  mem_we;
    logic                  in_fire;
    logic                  cfg_wr;

    logic [PROD_W-1:0]     prod;
    logic [NEED_W-1:0]     need;
    logic                  search_hit;
    logic                  search_done;
    logic                  commit_last;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign prdata = (paddr[2] == REG_MAX_OP) ? {{(32-MAX_OP_W){1'b0}}, max_op_reg}
                                             : {{(32-LOG_AREA_W){1'b0}}, log_area_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_area_reg <= LOG_AREA_RESET;
            max_op_reg   <= MAX_OP_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_LOG_AREA)
                log_area_reg <= pwdata[LOG_AREA_W-1:0];
            else
                max_op_reg <= pwdata[MAX_OP_W-1:0];
        end
    end

    // handshakes
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid & s_axis_tready;
    assign out_free      = !out_vld_reg || m_axis_tready;

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {7'd0, out_slot_reg, out_block_reg, out_status_reg};

    // shared arithmetic
    assign idx_inc     = idx_reg + 1'b1;
    assign prod        = PROD_W'({1'b0, active_reg} + 1'b1) * PROD_W'(max_op_reg);
    assign need        = NEED_W'(count_reg) + NEED_W'(prod);
    assign search_hit  = cmp_vld_reg && (rd_data_reg == blk_reg);
    assign search_done = !cmp_vld_reg && (idx_reg == count_reg);
    assign commit_last = (idx_inc == count_reg);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cmp_vld_next    = 1'b0;
        count_next      = count_reg;
        active_next     = active_reg;
        res_status_next = res_status_reg;
        res_block_next  = res_block_reg;
        res_slot_next   = res_slot_reg;
        out_vld_next    = out_vld_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_block_next  = out_block_reg;
        out_slot_next   = out_slot_reg;
        out_last_next   = out_last_reg;
        rd_addr         = idx_reg[IW-1:0];
        mem_we          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                    state_next = S_DECODE;
            end

            S_DECODE:
            begin
                res_block_next = '0;
                res_slot_next  = '0;
                idx_next       = '0;
                state_next     = S_EMIT;
                case (op_reg)
                    OP_BEGIN:
                    begin
                        if (active_reg == ACTIVE_MAX || need > NEED_W'(TABLE_DEPTH))
                            res_status_next = ST_WAIT;
                        else
                        begin
                            res_status_next = ST_GRANTED;
                            active_next     = active_reg + 1'b1;
                        end
                    end
                    OP_END:
                    begin
                        if (active_reg == '0)
                            res_status_next = ST_END_ERR;
                        else
                        begin
                            active_next = active_reg - 1'b1;
                            if (active_reg != ACTIVE_W'(1))
                                res_status_next = ST_RELEASED;
                            else if (count_reg == '0)
                                res_status_next = ST_EMPTY;
                            else
                                state_next = S_COMMIT_PRIME;
                        end
                    end
                    OP_LOG:
                    begin
                        res_block_next = blk_reg;
                        if (count_reg >= CW'(TABLE_DEPTH) ||
                            CMP_W'(count_reg) + 1'b1 >= CMP_W'(log_area_reg))
                            res_status_next = ST_FULL;
                        else if (active_reg == '0)
                            res_status_next = ST_NO_OP;
                        else
                            state_next = S_SEARCH;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_SEARCH:
            begin
                if (search_hit)
                begin
                    res_status_next = ST_ABSORBED;
                    res_slot_next   = SLOT_W'(idx_reg - 1'b1);
                    state_next      = S_EMIT;
                end
                else if (search_done)
                begin
                    mem_we          = 1'b1;
                    count_next      = count_reg + 1'b1;
                    res_status_next = ST_APPENDED;
                    res_slot_next   = SLOT_W'(count_reg);
                    state_next      = S_EMIT;
                end
                else
                begin
                    cmp_vld_next = (idx_reg < count_reg);
                    if (idx_reg < count_reg)
                        idx_next = idx_inc;
                end
            end

            S_COMMIT_PRIME:
            begin
                rd_addr    = '0;
                state_next = S_COMMIT;
            end

            S_COMMIT:
            begin
                if (out_free)
                begin
                    out_vld_next    = 1'b1;
                    out_status_next = ST_COMMIT;
                    out_block_next  = BLKOUT_W'(rd_data_reg);
                    out_slot_next   = SLOT_W'(idx_reg);
                    out_last_next   = commit_last;
                    rd_addr         = idx_inc[IW-1:0];
                    idx_next        = idx_inc;
                    if (commit_last)
                    begin
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_vld_next    = 1'b1;
                    out_status_next = res_status_reg;
                    out_block_next  = BLKOUT_W'(res_block_reg);
                    out_slot_next   = res_slot_reg;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            idx_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            count_reg   <= '0;
            active_reg  <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            cmp_vld_reg <= cmp_vld_next;
            count_reg   <= count_next;
            active_reg  <= active_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg  <= s_axis_tdata[1:0];
            blk_reg <= s_axis_tdata[SB+1:2];
        end
        res_status_reg <= res_status_next;
        res_block_reg  <= res_block_next;
        res_slot_reg   <= res_slot_next;
        out_status_reg <= out_status_next;
        out_block_reg  <= out_block_next;
        out_slot_reg   <= out_slot_next;
        out_last_reg   <= out_last_next;
    end

    // block number table
    always_ff @(posedge clk)
    begin
        if (mem_we)
            table_mem[count_reg[IW-1:0]] <= blk_reg;
        rd_data_reg <= table_mem[rd_addr];
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("logged count above table depth");

    a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH && !search_hit && search_done)
            |=> count_reg == $past(count_reg) + 1'b1)
        else $error("append did not advance logged count");

    a_commit_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMMIT && out_free && commit_last)
            |=> count_reg == '0 && state_reg == S_IDLE)
        else $error("commit run did not clear the table");

    a_active_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_DECODE) |=> $stable(active_reg))
        else $error("active count changed outside decode");

endmodule

// ===== tb/sv/journal_block_tracker_checker.sv =====
// ----------------------------------------------------------------------------
// journal_block_tracker_checker
// watches the input, result and register channels of the journal block
// tracker. It keeps its own copy of the logged table, the counts and the
// register values, works out the results that each accepted transaction
// must cause, and compares every accepted result field by field with the
// oldest one still awaited.
// ----------------------------------------------------------------------------
module journal_block_tracker_checker
    import jbt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // opcode[1:0], block_number[33:2], zero pad
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,   // status[3:0], block_out[35:4], slot[40:36], pad
    input  logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatch_count,
    output int          pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH = DEF_TABLE_DEPTH;

    typedef struct packed {
        status_t     status;
        logic [31:0] block_out;
        logic [4:0]  slot;
        logic        last;
    } tracker_result_t;

    tracker_result_t awaited_results[$];

    logic [31:0] shadow_blocks [DEPTH];
    int unsigned shadow_count;
    int unsigned shadow_active;
    int unsigned shadow_log_area;
    int unsigned shadow_max_op;

    function automatic void push_result(status_t status, logic [31:0] blk, logic [4:0] slot,
                                        logic last);
        tracker_result_t r;
        r.status    = status;
        r.block_out = blk;
        r.slot      = slot;
        r.last      = last;
        awaited_results.push_back(r);
    endfunction

    function automatic void compute_tracker_results(logic [1:0] op, logic [31:0] blk);
        int unsigned need;
        int          hit;
        need = shadow_count + (shadow_active + 1) * shadow_max_op;
        hit  = -1;
        case (op)
            OP_BEGIN:
            begin
                if (shadow_active >= ACTIVE_MAX || need > DEPTH)
                    push_result(ST_WAIT, '0, '0, 1'b1);
                else
                begin
                    shadow_active++;
                    push_result(ST_GRANTED, '0, '0, 1'b1);
                end
            end
            OP_END:
            begin
                if (shadow_active == 0)
                    push_result(ST_END_ERR, '0, '0, 1'b1);
                else
                begin
                    shadow_active--;
                    if (shadow_active != 0)
                        push_result(ST_RELEASED, '0, '0, 1'b1);
                    else if (shadow_count == 0)
                        push_result(ST_EMPTY, '0, '0, 1'b1);
                    else
                    begin
                        // commit run in table order, then the table empties
                        for (int i = 0; i < shadow_count; i++)
                            push_result(ST_COMMIT, shadow_blocks[i], 5'(i),
                                        i == shadow_count - 1);
                        shadow_count = 0;
                    end
                end
            end
            OP_LOG:
            begin
                // full takes precedence even over a block already present
                if (shadow_count >= DEPTH || shadow_count + 1 >= shadow_log_area)
                    push_result(ST_FULL, blk, '0, 1'b1);
                else if (shadow_active == 0)
                    push_result(ST_NO_OP, blk, '0, 1'b1);
                else
                begin
                    for (int i = 0; i < shadow_count; i++)
                        if (hit < 0 && shadow_blocks[i] == blk)
                            hit = i;
                    if (hit >= 0)
                        push_result(ST_ABSORBED, blk, 5'(hit), 1'b1);
                    else
                    begin
                        shadow_blocks[shadow_count] = blk;
                        push_result(ST_APPENDED, blk, 5'(shadow_count), 1'b1);
                        shadow_count++;
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void check_result(tracker_result_t got);
        tracker_result_t want;
        if (awaited_results.size() == 0)
        begin
            $error("unexpected result: status %0d block_out %h slot %0d last %0d",
                   got.status, got.block_out, got.slot, got.last);
            mismatch_count++;
            return;
        end
        want = awaited_results.pop_front();
        if (got.status != want.status)
        begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            mismatch_count++;
        end
        if (got.block_out != want.block_out)
        begin
            $error("block_out: expected %h, actual %h", want.block_out, got.block_out);
            mismatch_count++;
        end
        if (got.slot != want.slot)
        begin
            $error("slot: expected %0d, actual %0d", want.slot, got.slot);
            mismatch_count++;
        end
        if (got.last != want.last)
        begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            mismatch_count++;
        end
    endfunction

    initial
    begin
        mismatch_count  = 0;
        pending_results = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_count    = 0;
            shadow_active   = 0;
            shadow_log_area = LOG_AREA_RESET;
            shadow_max_op   = MAX_OP_RESET;
            awaited_results.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_MAX_OP)
                    shadow_max_op = pwdata[MAX_OP_W-1:0];
                else
                    shadow_log_area = pwdata[LOG_AREA_W-1:0];
            end
            if (m_axis_tvalid && m_axis_tready)
                check_result({status_t'(m_axis_tdata[3:0]), m_axis_tdata[35:4],
                              m_axis_tdata[40:36], m_axis_tlast});
            if (s_axis_tvalid && s_axis_tready)
                compute_tracker_results(s_axis_tdata[1:0], s_axis_tdata[33:2]);
        end
        pending_results = awaited_results.size();
    end

endmodule

// ===== tb/sv/journal_block_tracker_tb.sv =====
// ----------------------------------------------------------------------------
// journal_block_tracker_tb
// drives the journal block tracker with a directed run of admission, logging,
// absorption and commit cases, then with random journal transactions under
// several register settings and handshake idling patterns; the checker
// beside the block judges every result
// ----------------------------------------------------------------------------
module journal_block_tracker_tb;
    import jbt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_SPARE       = 2'd3;
    localparam int         PHASE_ITEMS    = 90;
    localparam int         SETTLE_CYCLES  = 48;
    localparam int         RX_HOLD_CYCLES = 300;
    localparam int         QUIET_LIMIT    = 3000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // opcode[1:0], block_number[33:2], zero pad
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // status[3:0], block_out[35:4], slot[40:36], pad
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int mismatch_count;
    int pending_results;
    int tx_idle_pct;
    int rx_stall_pct;
    logic hold_rx;

    journal_block_tracker dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    journal_block_tracker_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tlast    (m_axis_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_rx)
            begin
                m_axis_tready = 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge clk);
                hold_rx = 1'b0;
            end
            m_axis_tready = ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("journal_block_tracker regression: fail");
        $finish;
    end

    task automatic send_item(input logic [1:0] op, input logic [31:0] blk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tdata  = {6'b0, blk, op};
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic drain_tracker();
        s_axis_tvalid = 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic reg_index, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {reg_index, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // small pool so that repeated writes get absorbed
    function automatic logic [31:0] pick_block();
        case ($urandom_range(9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h0000_0001;
            3: return 32'h8000_0000;
            4: return 32'h5555_5555;
            5: return 32'hAAAA_AAAA;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_phase(input int log_area, input int max_op, input int idle_pct,
                             input int stall_pct, input logic long_hold);
        int issued;
        int ops;
        int writes;
        logic [1:0] op;
        drain_tracker();
        write_reg(REG_LOG_AREA, log_area);
        write_reg(REG_MAX_OP, max_op);
        tx_idle_pct  = idle_pct;
        rx_stall_pct = stall_pct;
        hold_rx      = long_hold;
        issued       = 0;
        while (issued < PHASE_ITEMS)
        begin
            if ($urandom_range(9) == 0)
            begin
                // stray transaction
                op = 2'($urandom_range(3));
                send_item(op, $urandom);
                if (op != OP_SPARE)
                    issued++;
            end
            else
            begin
                ops    = $urandom_range(3, 1);
                writes = ($urandom_range(7) == 0) ? $urandom_range(36, 30)
                                                  : $urandom_range(6, 0);
                repeat (ops) send_item(OP_BEGIN, $urandom);
                repeat (writes) send_item(OP_LOG, pick_block());
                repeat (ops) send_item(OP_END, $urandom);
                issued += 2 * ops + writes;
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        hold_rx       = 1'b0;
        tx_idle_pct   = 0;
        rx_stall_pct  = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // nothing active yet
        send_item(OP_END, 32'h0000_0000);
        send_item(OP_LOG, 32'hFFFF_FFFF);
        send_item(OP_SPARE, 32'h1234_5678);
        // admission up to the table size
        repeat (4) send_item(OP_BEGIN, 32'h0000_0000);
        send_item(OP_LOG, 32'h0000_0000);
        send_item(OP_LOG, 32'hFFFF_FFFF);
        send_item(OP_LOG, 32'h0000_0000);
        send_item(OP_LOG, 32'h8000_0001);
        repeat (3) send_item(OP_END, 32'hFFFF_FFFF);
        // empty commit
        send_item(OP_BEGIN, 32'h0000_0000);
        send_item(OP_END, 32'h0000_0000);

        // smallest log area that admits a log write, largest budget that admits a transaction
        drain_tracker();
        write_reg(REG_LOG_AREA, 32'd2);
        write_reg(REG_MAX_OP, 32'd32);
        send_item(OP_BEGIN, 32'h0000_0000);
        send_item(OP_BEGIN, 32'h0000_0000);
        send_item(OP_LOG, 32'h5555_5555);
        send_item(OP_LOG, 32'hAAAA_AAAA);
        send_item(OP_LOG, 32'h5555_5555);
        send_item(OP_END, 32'h0000_0000);

        run_phase(1024, 1, 0, 0, 1'b1);
        run_phase(20, 7, 81, 0, 1'b0);
        run_phase(1024, 32, 0, 81, 1'b0);
        run_phase(12, 3, 9, 9, 1'b0);

        drain_tracker();
        if (mismatch_count == 0 && pending_results == 0)
            $display("journal_block_tracker regression: pass");
        else
            $display("journal_block_tracker regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/jbt_pkg.sv
rtl/journal_block_tracker.sv
tb/sv/journal_block_tracker_checker.sv
tb/sv/journal_block_tracker_tb.sv
